// ===== design/dpfm_pkg.sv =====
// Shared types, constants and helpers of the demand-paging frame manager.
// No dependencies; taken in by scoped names by every other file.
package dpfm_pkg;

    // Sizing of the frame pool and the per-process page tables
    localparam int NUM_FRAMES = 64;
    localparam int FRAME_W    = 6;
    localparam int MAX_PROCS  = 16;
    localparam int PROC_W     = 4;
    localparam int MAX_PAGES  = 64;
    localparam int PAGE_W     = 6;
    localparam int COUNT_W    = 7;
    localparam int PTE_AW     = PROC_W + PAGE_W;
    localparam int WORD_W     = 17;

    // Page shift limits and reset value
    localparam logic [3:0] SHIFT_MIN   = 4'd4;
    localparam logic [3:0] SHIFT_MAX   = 4'd12;
    localparam logic [3:0] SHIFT_RESET = 4'd8;

    // Request codes
    localparam logic [1:0] REQ_CREATE  = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_WRITE   = 2'd2;
    localparam logic [1:0] REQ_RELEASE = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNKNOWN   = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_TOO_LARGE = 2'd3;

    // One page-table entry
    typedef struct packed {
        logic               valid;
        logic               dirty;
        logic [FRAME_W-1:0] frame;
    } pte_t;

    // Commands from the sequencer to the frame pool
    typedef struct packed {
        logic               pop;
        logic               push;
        logic [FRAME_W-1:0] push_frame;
        logic               claim;
        logic [FRAME_W-1:0] claim_frame;
        logic [PROC_W-1:0]  claim_proc;
        logic [PAGE_W-1:0]  claim_page;
        logic               victim_adv;
        logic               init_we;
        logic [FRAME_W-1:0] init_idx;
    } pool_cmd_t;

    // Status of the frame pool seen by the sequencer
    typedef struct packed {
        logic [COUNT_W-1:0] free_count;
        logic [FRAME_W-1:0] head_frame;
        logic [FRAME_W-1:0] victim_frame;
        logic               victim_in_use;
        logic [PROC_W-1:0]  owner_proc;
        logic [PAGE_W-1:0]  owner_page;
    } pool_stat_t;

    // Clamp the page shift into its legal range
    function automatic logic [3:0] eff_shift(input logic [3:0] sh);
        logic [3:0] r;
        r = sh;
        if (sh < SHIFT_MIN) r = SHIFT_MIN;
        if (sh > SHIFT_MAX) r = SHIFT_MAX;
        return r;
    endfunction

    // Physical word index: frame and offset joined, halved
    function automatic logic [WORD_W-1:0] word_of(input logic [FRAME_W-1:0] frame,
                                                  input logic [3:0] sh,
                                                  input logic [15:0] addr);
        logic [17:0] base;
        logic [17:0] mask;
        base = 18'(frame) << sh;
        mask = (18'd1 << sh) - 18'd1;
        return WORD_W'((base | (18'(addr) & mask)) >> 1);
    endfunction

endpackage

// ===== design/dpfm_if.sv =====
// Request and result channel interfaces of the frame manager.
// Depends on dpfm_pkg for field widths.
interface dpfm_req_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   req_type;
    logic [dpfm_pkg::PROC_W-1:0]  proc_id;
    logic [15:0]                  address;
    logic [15:0]                  size_bytes;

    modport source (output valid, req_type, proc_id, address, size_bytes, input ready);
    modport sink   (input valid, req_type, proc_id, address, size_bytes, output ready);
endinterface

interface dpfm_res_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic                          fault;
    logic [dpfm_pkg::WORD_W-1:0]   word_index;
    logic [dpfm_pkg::FRAME_W-1:0]  fill_frame;
    logic                          evict_dirty;
    logic [dpfm_pkg::PROC_W-1:0]   victim_proc;
    logic [dpfm_pkg::PAGE_W-1:0]   victim_page;
    logic [31:0]                   paged_in_total;
    logic [31:0]                   paged_out_total;
    logic [dpfm_pkg::COUNT_W-1:0]  used_frames;

    modport source (output valid, status, fault, word_index, fill_frame, evict_dirty,
                    victim_proc, victim_page, paged_in_total, paged_out_total,
                    used_frames, input ready);
    modport sink   (input valid, status, fault, word_index, fill_frame, evict_dirty,
                    victim_proc, victim_page, paged_in_total, paged_out_total,
                    used_frames, output ready);
endinterface

// ===== design/dpfm_frame_pool.sv =====
// Frame pool: free-frame FIFO memory, frame owner memory, in-use bits and
// the round-robin victim pointer. Depends on dpfm_pkg.
module dpfm_frame_pool
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dpfm_pkg::pool_cmd_t   cmd,
    output dpfm_pkg::pool_stat_t  stat
);

    logic [dpfm_pkg::FRAME_W-1:0] fifo_mem [dpfm_pkg::NUM_FRAMES];
    logic [dpfm_pkg::PROC_W+dpfm_pkg::PAGE_W-1:0] owner_mem [dpfm_pkg::NUM_FRAMES];

    logic [dpfm_pkg::FRAME_W-1:0]    head_reg, head_next;
    logic [dpfm_pkg::FRAME_W-1:0]    tail_reg, tail_next;
    logic [dpfm_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [dpfm_pkg::FRAME_W-1:0]    victim_reg, victim_next;
    logic [dpfm_pkg::NUM_FRAMES-1:0] in_use_reg, in_use_next;
    logic [dpfm_pkg::FRAME_W-1:0]    head_q_reg;
    logic [dpfm_pkg::PROC_W+dpfm_pkg::PAGE_W-1:0] owner_q_reg;
    logic                            push_ok;

    assign push_ok = cmd.push && (count_reg < dpfm_pkg::COUNT_W'(dpfm_pkg::NUM_FRAMES));

    // Advance pointers, count and in-use bits
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        victim_next = victim_reg;
        in_use_next = in_use_reg;
        if (cmd.pop)
        begin
            head_next  = head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        if (push_ok)
        begin
            tail_next  = tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        if (cmd.push)
            in_use_next[cmd.push_frame] = 1'b0;
        if (cmd.claim)
            in_use_next[cmd.claim_frame] = 1'b1;
        if (cmd.victim_adv)
            victim_next = victim_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= dpfm_pkg::COUNT_W'(dpfm_pkg::NUM_FRAMES);
            victim_reg <= '0;
            in_use_reg <= '0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            victim_reg <= victim_next;
            in_use_reg <= in_use_next;
        end
    end

    // Free FIFO memory: fill during the clearing pass, push when a release or re-create frees a frame
    always_ff @(posedge clk)
    begin
        if (cmd.init_we)
            fifo_mem[cmd.init_idx] <= cmd.init_idx;
        else if (push_ok)
            fifo_mem[tail_reg] <= cmd.push_frame;
        head_q_reg <= fifo_mem[head_reg];
    end

    // Owner memory: write on claim, read at the victim pointer
    always_ff @(posedge clk)
    begin
        if (cmd.claim)
            owner_mem[cmd.claim_frame] <= {cmd.claim_proc, cmd.claim_page};
        owner_q_reg <= owner_mem[victim_reg];
    end

    assign stat.free_count    = count_reg;
    assign stat.head_frame    = head_q_reg;
    assign stat.victim_frame  = victim_reg;
    assign stat.victim_in_use = in_use_reg[victim_reg];
    assign stat.owner_proc    = owner_q_reg[dpfm_pkg::PROC_W+dpfm_pkg::PAGE_W-1:dpfm_pkg::PAGE_W];
    assign stat.owner_page    = owner_q_reg[dpfm_pkg::PAGE_W-1:0];

endmodule

// ===== design/demand_paging_frame_manager.sv =====
// Top level of the demand-paging frame manager: sequencer, page-table
// memory and process table. Depends on dpfm_pkg, dpfm_if, dpfm_frame_pool.
//
// Usage
//   req (sink): one beat per request (create, read, write, release).
//   res (source): exactly one result beat per request, in order.
//   cfg_we / cfg_wdata: writes page_shift (log2 frame size, clamped 4..12).
//   After reset the page table is cleared, one entry a cycle, all 1024
//   entries, with req.ready low; configuration writes are taken meanwhile.
//   Steps per request: errors and creates of idle processes go from decode
//   straight to the result; an access hit reads its entry, then finishes;
//   a fault adds a fill step, and an eviction of a mapped frame a victim
//   lookup before it; release, or create of an active process, reads and
//   writes back each page in the table. The page-table memory has one read
//   and one write port with a registered read, so each entry takes a read
//   then a write-back. One request is in flight at a time.
//   The result sits in an output register; a new request is accepted while
//   it waits, and a stalled receiver holds the next result in its final
//   step until the register drains.
module demand_paging_frame_manager
(
    input  logic       clk,
    input  logic       rst_n,
    dpfm_req_if.sink   req,
    dpfm_res_if.source res,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata
);

    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_DECODE   = 9'b000000100,
        S_LOOK     = 9'b000001000,
        S_VLOOK    = 9'b000010000,
        S_FILL     = 9'b000100000,
        S_WALK_RD  = 9'b001000000,
        S_WALK_CHK = 9'b010000000,
        S_DONE     = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Page-table memory
    dpfm_pkg::pte_t                pte_mem [2**dpfm_pkg::PTE_AW];
    dpfm_pkg::pte_t                pte_q_reg;
    logic [dpfm_pkg::PTE_AW-1:0]   pte_ra;
    logic                          pte_we;
    logic [dpfm_pkg::PTE_AW-1:0]   pte_wa;
    dpfm_pkg::pte_t                pte_wd;

    // Frame pool link
    dpfm_pkg::pool_cmd_t  cmd;
    dpfm_pkg::pool_stat_t stat;

    // Process table
    logic [dpfm_pkg::COUNT_W-1:0] pcount_reg [dpfm_pkg::MAX_PROCS];
    logic [dpfm_pkg::COUNT_W-1:0] pcount_next [dpfm_pkg::MAX_PROCS];
    logic [dpfm_pkg::MAX_PROCS-1:0] active_reg, active_next;

    // Control and counters
    logic [3:0]                   shift_reg;
    logic [dpfm_pkg::PTE_AW-1:0]  clr_reg, clr_next;
    logic [dpfm_pkg::COUNT_W-1:0] walk_reg, walk_next;
    logic [31:0]                  pin_reg, pin_next;
    logic [31:0]                  pout_reg, pout_next;
    logic                         out_valid_reg, out_valid_next;

    // Request and working payload
    logic [1:0]                   type_reg, type_next;
    logic [dpfm_pkg::PROC_W-1:0]  proc_reg, proc_next;
    logic [15:0]                  addr_reg, addr_next;
    logic [15:0]                  size_reg, size_next;
    logic [dpfm_pkg::PAGE_W-1:0]  pg_reg, pg_next;
    logic [dpfm_pkg::FRAME_W-1:0] frame_reg, frame_next;
    logic [dpfm_pkg::COUNT_W-1:0] pages_reg, pages_next;
    logic [1:0]                   status_reg, status_next;
    logic                         fault_reg, fault_next;
    logic [dpfm_pkg::WORD_W-1:0]  word_reg, word_next;
    logic [dpfm_pkg::FRAME_W-1:0] fill_reg, fill_next;
    logic                         edirty_reg, edirty_next;
    logic [dpfm_pkg::PROC_W-1:0]  vproc_reg, vproc_next;
    logic [dpfm_pkg::PAGE_W-1:0]  vpage_reg, vpage_next;

    // Result register
    logic [1:0]                   o_status_reg;
    logic                         o_fault_reg;
    logic [dpfm_pkg::WORD_W-1:0]  o_word_reg;
    logic [dpfm_pkg::FRAME_W-1:0] o_fill_reg;
    logic                         o_edirty_reg;
    logic [dpfm_pkg::PROC_W-1:0]  o_vproc_reg;
    logic [dpfm_pkg::PAGE_W-1:0]  o_vpage_reg;
    logic [31:0]                  o_pin_reg;
    logic [31:0]                  o_pout_reg;
    logic [dpfm_pkg::COUNT_W-1:0] o_used_reg;
    logic                         load_out;

    // Decode helpers
    logic [3:0]                   sh;
    logic [16:0]                  size_sum;
    logic [16:0]                  create_pages;
    logic [15:0]                  acc_pg;
    logic [dpfm_pkg::COUNT_W-1:0] cur_count;
    logic                         cur_active;
    logic [dpfm_pkg::COUNT_W-1:0] walk_inc;

    assign sh           = dpfm_pkg::eff_shift(shift_reg);
    assign size_sum     = 17'(size_reg) + (17'd1 << sh) - 17'd1;
    assign create_pages = size_sum >> sh;
    assign acc_pg       = addr_reg >> sh;
    assign cur_count    = pcount_reg[proc_reg];
    assign cur_active   = active_reg[proc_reg];
    assign walk_inc     = walk_reg + 1'b1;

    dpfm_frame_pool u_pool
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    // Sequence each request through the page table and frame pool
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        walk_next      = walk_reg;
        pin_next       = pin_reg;
        pout_next      = pout_reg;
        pcount_next    = pcount_reg;
        active_next    = active_reg;
        type_next      = type_reg;
        proc_next      = proc_reg;
        addr_next      = addr_reg;
        size_next      = size_reg;
        pg_next        = pg_reg;
        frame_next     = frame_reg;
        pages_next     = pages_reg;
        status_next    = status_reg;
        fault_next     = fault_reg;
        word_next      = word_reg;
        fill_next      = fill_reg;
        edirty_next    = edirty_reg;
        vproc_next     = vproc_reg;
        vpage_next     = vpage_reg;
        pte_ra         = {proc_reg, pg_reg};
        pte_we         = 1'b0;
        pte_wa         = {proc_reg, pg_reg};
        pte_wd         = '0;
        cmd            = '0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !res.ready;

        case (state_reg)
            S_CLEAR:
            begin
                pte_we       = 1'b1;
                pte_wa       = clr_reg;
                cmd.init_we  = (clr_reg < dpfm_pkg::PTE_AW'(dpfm_pkg::NUM_FRAMES));
                cmd.init_idx = clr_reg[dpfm_pkg::FRAME_W-1:0];
                clr_next     = clr_reg + 1'b1;
                if (clr_reg == '1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    type_next  = req.req_type;
                    proc_next  = req.proc_id;
                    addr_next  = req.address;
                    size_next  = req.size_bytes;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                status_next = dpfm_pkg::ST_OK;
                fault_next  = 1'b0;
                word_next   = '0;
                fill_next   = '0;
                edirty_next = 1'b0;
                vproc_next  = '0;
                vpage_next  = '0;
                walk_next   = '0;
                state_next  = S_DONE;
                case (type_reg)
                    dpfm_pkg::REQ_CREATE:
                    begin
                        pages_next = create_pages[dpfm_pkg::COUNT_W-1:0];
                        if (create_pages > 17'(dpfm_pkg::MAX_PAGES))
                            status_next = dpfm_pkg::ST_TOO_LARGE;
                        else if (cur_active && cur_count != '0)
                            state_next = S_WALK_RD;
                        else
                        begin
                            pcount_next[proc_reg] = create_pages[dpfm_pkg::COUNT_W-1:0];
                            active_next[proc_reg] = 1'b1;
                        end
                    end
                    dpfm_pkg::REQ_RELEASE:
                    begin
                        if (!cur_active)
                            status_next = dpfm_pkg::ST_UNKNOWN;
                        else if (cur_count != '0)
                            state_next = S_WALK_RD;
                        else
                            active_next[proc_reg] = 1'b0;
                    end
                    default:
                    begin
                        if (!cur_active)
                            status_next = dpfm_pkg::ST_UNKNOWN;
                        else if (acc_pg >= 16'(cur_count))
                            status_next = dpfm_pkg::ST_RANGE;
                        else
                        begin
                            pg_next    = acc_pg[dpfm_pkg::PAGE_W-1:0];
                            pte_ra     = {proc_reg, acc_pg[dpfm_pkg::PAGE_W-1:0]};
                            state_next = S_LOOK;
                        end
                    end
                endcase
            end
            S_LOOK:
            begin
                if (pte_q_reg.valid)
                begin
                    word_next  = dpfm_pkg::word_of(pte_q_reg.frame, sh, addr_reg);
                    state_next = S_DONE;
                    if (type_reg == dpfm_pkg::REQ_WRITE)
                    begin
                        pte_we       = 1'b1;
                        pte_wd.valid = 1'b1;
                        pte_wd.dirty = 1'b1;
                        pte_wd.frame = pte_q_reg.frame;
                    end
                end
                else
                begin
                    fault_next = 1'b1;
                    state_next = S_FILL;
                    if (stat.free_count != '0)
                    begin
                        frame_next = stat.head_frame;
                        cmd.pop    = 1'b1;
                    end
                    else
                    begin
                        frame_next     = stat.victim_frame;
                        cmd.victim_adv = 1'b1;
                        if (stat.victim_in_use)
                        begin
                            vproc_next = stat.owner_proc;
                            vpage_next = stat.owner_page;
                            pte_ra     = {stat.owner_proc, stat.owner_page};
                            state_next = S_VLOOK;
                        end
                    end
                end
            end
            S_VLOOK:
            begin
                // Invalidate the victim's mapping, report it if dirty
                if (pte_q_reg.dirty)
                begin
                    edirty_next = 1'b1;
                    pout_next   = pout_reg + 32'd1;
                end
                pte_we     = 1'b1;
                pte_wa     = {vproc_reg, vpage_reg};
                state_next = S_FILL;
            end
            S_FILL:
            begin
                pte_we          = 1'b1;
                pte_wd.valid    = 1'b1;
                pte_wd.dirty    = (type_reg == dpfm_pkg::REQ_WRITE);
                pte_wd.frame    = frame_reg;
                cmd.claim       = 1'b1;
                cmd.claim_frame = frame_reg;
                cmd.claim_proc  = proc_reg;
                cmd.claim_page  = pg_reg;
                pin_next        = pin_reg + 32'd1;
                fill_next       = frame_reg;
                word_next       = dpfm_pkg::word_of(frame_reg, sh, addr_reg);
                state_next      = S_DONE;
            end
            S_WALK_RD:
            begin
                pte_ra     = {proc_reg, walk_reg[dpfm_pkg::PAGE_W-1:0]};
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                // Drop the entry and return its frame, if mapped, to the free list
                pte_we = 1'b1;
                pte_wa = {proc_reg, walk_reg[dpfm_pkg::PAGE_W-1:0]};
                if (pte_q_reg.valid)
                begin
                    cmd.push       = 1'b1;
                    cmd.push_frame = pte_q_reg.frame;
                end
                walk_next = walk_inc;
                if (walk_inc >= cur_count)
                begin
                    if (type_reg == dpfm_pkg::REQ_CREATE)
                    begin
                        pcount_next[proc_reg] = pages_reg;
                        active_next[proc_reg] = 1'b1;
                    end
                    else
                    begin
                        pcount_next[proc_reg] = '0;
                        active_next[proc_reg] = 1'b0;
                    end
                    state_next = S_DONE;
                end
                else
                    state_next = S_WALK_RD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            walk_reg      <= '0;
            pin_reg       <= '0;
            pout_reg      <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
            shift_reg     <= dpfm_pkg::SHIFT_RESET;
            for (int i = 0; i < dpfm_pkg::MAX_PROCS; i++)
                pcount_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            walk_reg      <= walk_next;
            pin_reg       <= pin_next;
            pout_reg      <= pout_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            pcount_reg    <= pcount_next;
            if (cfg_we)
                shift_reg <= cfg_wdata;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        type_reg   <= type_next;
        proc_reg   <= proc_next;
        addr_reg   <= addr_next;
        size_reg   <= size_next;
        pg_reg     <= pg_next;
        frame_reg  <= frame_next;
        pages_reg  <= pages_next;
        status_reg <= status_next;
        fault_reg  <= fault_next;
        word_reg   <= word_next;
        fill_reg   <= fill_next;
        edirty_reg <= edirty_next;
        vproc_reg  <= vproc_next;
        vpage_reg  <= vpage_next;
    end

    // Result register: load the finished result
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            o_status_reg <= status_reg;
            o_fault_reg  <= fault_reg;
            o_word_reg   <= word_reg;
            o_fill_reg   <= fill_reg;
            o_edirty_reg <= edirty_reg;
            o_vproc_reg  <= vproc_reg;
            o_vpage_reg  <= vpage_reg;
            o_pin_reg    <= pin_reg;
            o_pout_reg   <= pout_reg;
            o_used_reg   <= dpfm_pkg::COUNT_W'(dpfm_pkg::NUM_FRAMES) - stat.free_count;
        end
    end

    // Page-table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (pte_we)
            pte_mem[pte_wa] <= pte_wd;
        pte_q_reg <= pte_mem[pte_ra];
    end

    assign req.ready           = (state_reg == S_IDLE);
    assign res.valid           = out_valid_reg;
    assign res.status          = o_status_reg;
    assign res.fault           = o_fault_reg;
    assign res.word_index      = o_word_reg;
    assign res.fill_frame      = o_fill_reg;
    assign res.evict_dirty     = o_edirty_reg;
    assign res.victim_proc     = o_vproc_reg;
    assign res.victim_page     = o_vpage_reg;
    assign res.paged_in_total  = o_pin_reg;
    assign res.paged_out_total = o_pout_reg;
    assign res.used_frames     = o_used_reg;

    // An accepted beat always starts work
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg == S_DECODE)
        else $error("accepted request did not start decoding");

    // The free list never holds more frames than exist
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.free_count <= dpfm_pkg::COUNT_W'(dpfm_pkg::NUM_FRAMES))
        else $error("free count beyond frame total");

    // A fault is only reported on a successful access
    a_fault_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.fault |-> res.status == dpfm_pkg::ST_OK)
        else $error("fault reported with error status");

    // A dirty eviction always comes with a fault
    a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.evict_dirty |-> res.fault)
        else $error("eviction reported without fault");

    // Eviction only happens when the free list is empty
    a_evict_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_VLOOK |-> $past(stat.free_count) == '0)
        else $error("eviction while free frames remain");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the demand-paging frame manager: a directed table,
// then random traffic checked against a behavioural page-table predictor.
// Depends on dpfm_pkg, dpfm_if and demand_paging_frame_manager.
`timescale 1ns / 100ps

module tb_top;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  pid;
        logic [15:0] addr;
        logic [15:0] size;
    } op_t;

    typedef struct packed {
        logic [1:0]                  status;
        logic                        fault;
        logic [dpfm_pkg::WORD_W-1:0] word;
        logic [5:0]                  fill;
        logic                        edirty;
        logic [3:0]                  vproc;
        logic [5:0]                  vpage;
        logic [31:0]                 pin;
        logic [31:0]                 pout;
        logic [6:0]                  used;
    } xlat_t;

    typedef struct {
        op_t        op;
        logic       chk_status;
        logic [1:0] status;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [3:0] cfg_wdata = 4'd0;
    int   errors = 0;
    int   cycles = 0;
    bit   calm = 1'b0;

    dpfm_req_if req ();
    dpfm_res_if res ();

    demand_paging_frame_manager dut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .res(res.source),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // Predictor state
    logic [3:0] m_shift;
    bit         m_valid [1024];
    bit         m_dirty [1024];
    logic [5:0] m_frame [1024];
    int         m_pages [16];
    bit         m_active[16];
    logic [3:0] m_oproc [64];
    logic [5:0] m_opage [64];
    bit         m_inuse [64];
    logic [5:0] m_fifo  [64];
    int m_head, m_tail, m_free, m_victim;
    logic [31:0] m_pin, m_pout;

    // Expected results in flight, a ring written on accept, read on result
    xlat_t      exp_mem [256];
    bit         chk_mem [256];
    logic [1:0] st_mem  [256];
    logic [7:0] wr_ptr = '0;
    logic [7:0] rd_ptr = '0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk) cycles <= cycles + 1;

    function automatic void model_reset();
        m_shift = dpfm_pkg::SHIFT_RESET;
        for (int i = 0; i < 1024; i++)
        begin
            m_valid[i] = 0; m_dirty[i] = 0; m_frame[i] = 0;
        end
        for (int i = 0; i < 16; i++)
        begin
            m_pages[i] = 0; m_active[i] = 0;
        end
        for (int i = 0; i < 64; i++)
        begin
            m_inuse[i] = 0; m_fifo[i] = 6'(i); m_oproc[i] = 0; m_opage[i] = 0;
        end
        m_head = 0; m_tail = 0; m_free = 64; m_victim = 0; m_pin = 0; m_pout = 0;
    endfunction

    // Drop every mapping of a process and return its frames to the free list
    function automatic void free_process(int p);
        int e;
        for (int pg = 0; pg < m_pages[p] && pg < 64; pg++)
        begin
            e = p * 64 + pg;
            if (m_valid[e])
            begin
                m_inuse[m_frame[e]] = 0;
                if (m_free < 64)
                begin
                    m_fifo[m_tail] = m_frame[e];
                    m_tail = (m_tail + 1) % 64;
                    m_free++;
                end
            end
            m_valid[e] = 0;
            m_dirty[e] = 0;
        end
        m_active[p] = 0;
        m_pages[p] = 0;
    endfunction

    function automatic xlat_t translate(op_t op);
        xlat_t r;
        int sh, pages, pg, off, e, f, ve;
        r = '0;
        sh = (m_shift < 4) ? 4 : (m_shift > 12) ? 12 : m_shift;
        if (op.kind == dpfm_pkg::REQ_CREATE)
        begin
            pages = (op.size + (1 << sh) - 1) >> sh;
            if (pages > 64) r.status = dpfm_pkg::ST_TOO_LARGE;
            else
            begin
                if (m_active[op.pid]) free_process(op.pid);
                m_pages[op.pid] = pages;
                m_active[op.pid] = 1;
            end
        end
        else if (op.kind == dpfm_pkg::REQ_RELEASE)
        begin
            if (!m_active[op.pid]) r.status = dpfm_pkg::ST_UNKNOWN;
            else free_process(op.pid);
        end
        else if (!m_active[op.pid]) r.status = dpfm_pkg::ST_UNKNOWN;
        else
        begin
            pg = op.addr >> sh;
            off = op.addr & ((1 << sh) - 1);
            if (pg >= m_pages[op.pid]) r.status = dpfm_pkg::ST_RANGE;
            else
            begin
                e = op.pid * 64 + pg;
                if (!m_valid[e])
                begin
                    r.fault = 1;
                    if (m_free > 0)
                    begin
                        f = m_fifo[m_head];
                        m_head = (m_head + 1) % 64;
                        m_free--;
                    end
                    else
                    begin
                        f = m_victim;
                        m_victim = (m_victim + 1) % 64;
                        if (m_inuse[f])
                        begin
                            ve = m_oproc[f] * 64 + m_opage[f];
                            if (m_dirty[ve])
                            begin
                                r.edirty = 1;
                                m_pout++;
                            end
                            m_valid[ve] = 0;
                            m_dirty[ve] = 0;
                            r.vproc = m_oproc[f];
                            r.vpage = m_opage[f];
                        end
                    end
                    m_pin++;
                    m_inuse[f] = 1;
                    m_oproc[f] = op.pid;
                    m_opage[f] = 6'(pg);
                    m_frame[e] = 6'(f);
                    m_valid[e] = 1;
                    m_dirty[e] = 0;
                    r.fill = 6'(f);
                end
                if (op.kind == dpfm_pkg::REQ_WRITE) m_dirty[e] = 1;
                r.word = dpfm_pkg::WORD_W'(((m_frame[e] << sh) + off) >> 1);
            end
        end
        r.pin = m_pin;
        r.pout = m_pout;
        r.used = 7'(64 - m_free);
        return r;
    endfunction

    // Hand one request beat to the block and queue its expected result
    task automatic send_op(op_t op, bit chk = 0, logic [1:0] st = dpfm_pkg::ST_OK);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            gap = $urandom_range(1, 19);
            repeat (gap) @(negedge clk);
        end
        req.valid <= 1'b1;
        req.req_type <= op.kind;
        req.proc_id <= op.pid;
        req.address <= op.addr;
        req.size_bytes <= op.size;
        do @(posedge clk); while (!req.ready);
        exp_mem[wr_ptr] = translate(op);
        chk_mem[wr_ptr] = chk;
        st_mem[wr_ptr] = st;
        wr_ptr = wr_ptr + 8'd1;
        @(negedge clk);
    endtask

    task automatic idle_req();
        req.valid <= 1'b0;
    endtask

    task automatic drain();
        while (wr_ptr != rd_ptr) @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic set_shift(logic [3:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        m_shift = v;
    endtask

    // Result side: random stalls, compare each beat with the oldest expectation
    initial
    begin
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            res.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        xlat_t want, got;
        bit chk;
        logic [1:0] st;
        if (rst_n && res.valid && res.ready)
        begin
            got = '{res.status, res.fault, res.word_index, res.fill_frame, res.evict_dirty,
                    res.victim_proc, res.victim_page, res.paged_in_total,
                    res.paged_out_total, res.used_frames};
            if (wr_ptr == rd_ptr)
            begin
                $display("%0t unexpected beat: expected none actual %p", $realtime, got);
                errors++;
            end
            else
            begin
                want = exp_mem[rd_ptr];
                chk = chk_mem[rd_ptr];
                st = st_mem[rd_ptr];
                rd_ptr = rd_ptr + 8'd1;
                if (chk && got.status != st)
                begin
                    $display("%0t status: expected %0d actual %0d", $realtime, st, got.status);
                    errors++;
                end
                if (got !== want)
                begin
                    $display("%0t mismatch: expected %p actual %p", $realtime, want, got);
                    errors++;
                end
            end
        end
    end

    // Timeout watchdog
    always @(posedge clk)
    begin
        if (cycles > 2000000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic op_t rand_op(int hot);
        op_t op;
        int r;
        r = $urandom_range(0, 99);
        op.pid = (hot > 0) ? 4'($urandom_range(0, hot - 1)) : 4'($urandom);
        op.addr = 16'($urandom);
        op.size = 16'($urandom);
        if (r < 6)
        begin
            op.kind = dpfm_pkg::REQ_CREATE;
            if ($urandom_range(0, 4) != 0) op.size = 16'($urandom_range(0, 6000));
        end
        else if (r < 9) op.kind = dpfm_pkg::REQ_RELEASE;
        else
        begin
            op.kind = ($urandom_range(0, 1) != 0) ? dpfm_pkg::REQ_WRITE : dpfm_pkg::REQ_READ;
            if ($urandom_range(0, 9) != 0) op.addr = 16'($urandom_range(0, 6000));
        end
        return op;
    endfunction

    initial
    begin
        row_t rows[$];
        logic [3:0] shifts[6];
        shifts = '{4'd8, 4'd4, 4'd12, 4'd0, 4'd15, 4'd6};
        req.valid = 1'b0;
        req.req_type = dpfm_pkg::REQ_CREATE;
        req.proc_id = '0;
        req.address = '0;
        req.size_bytes = '0;
        model_reset();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: errors, extremes and every request kind
        rows = '{
            '{'{dpfm_pkg::REQ_READ, 4'd0, 16'd0, 16'd0}, 1, dpfm_pkg::ST_UNKNOWN},
            '{'{dpfm_pkg::REQ_RELEASE, 4'd15, 16'd0, 16'd0}, 1, dpfm_pkg::ST_UNKNOWN},
            '{'{dpfm_pkg::REQ_CREATE, 4'd0, 16'd0, 16'd65535}, 1, dpfm_pkg::ST_TOO_LARGE},
            '{'{dpfm_pkg::REQ_CREATE, 4'd0, 16'd0, 16'd16384}, 1, dpfm_pkg::ST_OK},
            '{'{dpfm_pkg::REQ_CREATE, 4'd15, 16'd0, 16'd16385}, 1, dpfm_pkg::ST_TOO_LARGE},
            '{'{dpfm_pkg::REQ_CREATE, 4'd15, 16'd0, 16'd0}, 1, dpfm_pkg::ST_OK},
            '{'{dpfm_pkg::REQ_READ, 4'd15, 16'd0, 16'd0}, 1, dpfm_pkg::ST_RANGE},
            '{'{dpfm_pkg::REQ_WRITE, 4'd0, 16'd16383, 16'd0}, 0, dpfm_pkg::ST_OK},
            '{'{dpfm_pkg::REQ_READ, 4'd0, 16'd16383, 16'd0}, 0, dpfm_pkg::ST_OK},
            '{'{dpfm_pkg::REQ_READ, 4'd0, 16'd65535, 16'd0}, 1, dpfm_pkg::ST_RANGE},
            '{'{dpfm_pkg::REQ_WRITE, 4'd0, 16'd0, 16'd0}, 0, dpfm_pkg::ST_OK},
            '{'{dpfm_pkg::REQ_CREATE, 4'd1, 16'd0, 16'd300}, 0, dpfm_pkg::ST_OK},
            '{'{dpfm_pkg::REQ_READ, 4'd1, 16'd511, 16'd0}, 0, dpfm_pkg::ST_OK},
            '{'{dpfm_pkg::REQ_CREATE, 4'd1, 16'd0, 16'd1}, 0, dpfm_pkg::ST_OK},
            '{'{dpfm_pkg::REQ_RELEASE, 4'd0, 16'd0, 16'd0}, 1, dpfm_pkg::ST_OK},
            '{'{dpfm_pkg::REQ_RELEASE, 4'd0, 16'd0, 16'd0}, 1, dpfm_pkg::ST_UNKNOWN}
        };
        foreach (rows[i]) send_op(rows[i].op, rows[i].chk_status, rows[i].status);
        // Fill every frame from one process, then force dirty evictions
        send_op('{dpfm_pkg::REQ_CREATE, 4'd2, 16'd0, 16'd16384});
        for (int pg = 0; pg < 64; pg++)
            send_op('{dpfm_pkg::REQ_WRITE, 4'd2, 16'(pg << 8), 16'd0});
        send_op('{dpfm_pkg::REQ_CREATE, 4'd3, 16'd0, 16'd2048});
        for (int pg = 0; pg < 8; pg++)
            send_op('{dpfm_pkg::REQ_READ, 4'd3, 16'(pg << 8), 16'd0});
        idle_req();
        drain();

        // Random phases across page-shift settings, extremes included
        foreach (shifts[s])
        begin
            set_shift(shifts[s]);
            for (int n = 0; n < 260; n++)
            begin
                if (s == 5 && n > 180) calm = 1'b1;
                send_op(rand_op((n % 3 == 0) ? 0 : 4));
            end
            idle_req();
            drain();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
